// ===== hdl/i2cmts_pkg.sv =====
// types, codes and constants shared by the i2c master transfer sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

  localparam int BUFFER_DEPTH_DEF = 32;

  // byte index is kept at six bits and stops at its top value
  localparam logic [5:0] INDEX_MAX = 6'd63;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2
  } command_t;

  typedef enum logic [3:0] {
    EV_START        = 4'd0,
    EV_REPSTART     = 4'd1,
    EV_MT_SLA_ACK   = 4'd2,
    EV_MT_DATA_ACK  = 4'd3,
    EV_MT_SLA_NACK  = 4'd4,
    EV_MT_DATA_NACK = 4'd5,
    EV_ARB_LOST     = 4'd6,
    EV_MR_SLA_ACK   = 4'd7,
    EV_MR_SLA_NACK  = 4'd8,
    EV_MR_DATA_ACK  = 4'd9,
    EV_MR_DATA_NACK = 4'd10,
    EV_OTHER        = 4'd11
  } bus_event_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RX_ACK  = 3'd3,
    ACT_RX_NACK = 3'd4,
    ACT_STOP    = 3'd5
  } bus_action_t;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] slave_address;
    logic [5:0] transfer_length;
    logic [3:0] bus_event;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] transmit_byte;
    logic       stored_valid;
    logic [4:0] stored_index;
    logic [7:0] stored_byte;
    logic       busy_res;
  } out_item_t;

  // buffer write request from the control logic
  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic [7:0] data;
  } buf_wr_t;

endpackage

`default_nettype wire

// ===== hdl/i2cmts_buf.sv =====
// transfer byte buffer with registered read and write forwarding
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_buf
  import i2cmts_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire buf_wr_t    wr,
  input  wire logic [5:0] rd_idx,
  output logic      [7:0] rd_data_r
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [8:0]    wr_wide;
  logic [8:0]    rd_wide;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_wide = {3'b000, wr.idx};
  assign rd_wide = {3'b000, rd_idx};
  assign wr_addr = wr_wide[AW-1:0];
  assign rd_addr = rd_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // read data always tracks the entry at the next byte index
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == rd_idx)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2cmts_ctrl.sv =====
// transfer state and per-item bus action decision
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_ctrl
  import i2cmts_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire in_item_t   item,
  input  wire logic [7:0] rd_data,
  output out_item_t       res,
  output buf_wr_t         wr,
  output logic      [5:0] rd_idx
);

  logic [7:0] addr_r, addr_nxt;
  logic [5:0] len_r, len_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;

  logic       load_in_buf;
  logic       idx_in_buf;
  logic [5:0] idx_adv;
  logic [2:0] rd_act;
  logic [2:0] rd_act_adv;

  assign load_in_buf = ({4'b0000, item.load_index} < 9'(BUFFER_DEPTH));
  assign idx_in_buf  = ({3'b000, idx_r} < 9'(BUFFER_DEPTH));
  assign idx_adv     = (idx_r == INDEX_MAX) ? idx_r : idx_r + 6'd1;
  // ack only while more than one byte is still to come
  assign rd_act      = (({1'b0, idx_r} + 7'd1) < {1'b0, len_r}) ? ACT_RX_ACK : ACT_RX_NACK;
  // same decision once the index has moved past the byte just received
  assign rd_act_adv  = (({1'b0, idx_adv} + 7'd1) < {1'b0, len_r}) ? ACT_RX_ACK : ACT_RX_NACK;

  always_comb begin
    addr_nxt = addr_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    res      = '0;
    wr       = '0;
    if (accept) begin
      case (item.command)
        CMD_LOAD: begin
          if (load_in_buf) begin
            wr.en   = 1'b1;
            wr.idx  = {1'b0, item.load_index};
            wr.data = item.load_byte;
          end
        end
        CMD_START: begin
          if (!busy_r) begin
            addr_nxt       = item.slave_address;
            len_nxt        = item.transfer_length;
            busy_nxt       = 1'b1;
            res.bus_action = ACT_START;
          end
        end
        CMD_EVENT: begin
          if (busy_r) begin
            case (item.bus_event)
              EV_START, EV_REPSTART: begin
                idx_nxt           = '0;
                res.bus_action    = ACT_SEND;
                res.transmit_byte = addr_r;
              end
              EV_MT_SLA_ACK, EV_MT_DATA_ACK: begin
                if (idx_r < len_r) begin
                  res.bus_action    = ACT_SEND;
                  res.transmit_byte = idx_in_buf ? rd_data : 8'h00;
                  idx_nxt           = idx_adv;
                end else begin
                  res.bus_action = ACT_STOP;
                  busy_nxt       = 1'b0;
                end
              end
              EV_MR_DATA_ACK, EV_MR_DATA_NACK: begin
                if (idx_in_buf) begin
                  wr.en            = 1'b1;
                  wr.idx           = idx_r;
                  wr.data          = item.received_byte;
                  res.stored_valid = 1'b1;
                  res.stored_index = idx_r[4:0];
                  res.stored_byte  = item.received_byte;
                end
                idx_nxt = idx_adv;
                if (item.bus_event == EV_MR_DATA_ACK) begin
                  res.bus_action = rd_act_adv;
                end else begin
                  res.bus_action = ACT_STOP;
                  busy_nxt       = 1'b0;
                end
              end
              EV_MR_SLA_ACK: begin
                res.bus_action = rd_act;
              end
              EV_ARB_LOST: begin
                res.bus_action = ACT_START;
              end
              default: begin
                res.bus_action = ACT_STOP;
                busy_nxt       = 1'b0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    res.busy_res = busy_nxt;
  end

  assign rd_idx = idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      len_r  <= '0;
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      len_r  <= len_nxt;
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2cmts_outq.sv =====
// result register with a skid entry behind it
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_outq
  import i2cmts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic      head_v_r, head_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t head_r, head_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop = head_v_r && !out_stall;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r || pop) begin
        head_nxt   = push_item;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_item;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      head_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_item  = head_r;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_transfer_sequencer.sv =====
// top level of the i2c master transfer sequencer
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for i2c master transfers. Each item is a buffer load, a start
// request or a bus status event, and each item gives exactly one result item
// holding the bus action to take, the byte to shift out, any received byte
// stored and the busy flag. An item is decided in the cycle it is accepted,
// and its result is registered into the output queue; one item can be taken
// every cycle while in_stall is low. The buffer is a single-port-write memory
// with a registered read that always holds the entry at the current byte index,
// so a send needs no separate read. A two-entry output queue lets the input
// keep accepting while a result waits; in_stall rises only once both entries
// are full. Buffer contents are undefined after reset until loaded or received.
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic       accept;
  logic       q_full;
  logic [7:0] rd_data;
  logic [5:0] rd_idx;
  buf_wr_t    wr;
  out_item_t  res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  i2cmts_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .rd_data(rd_data),
    .res    (res),
    .wr     (wr),
    .rd_idx (rd_idx)
  );

  i2cmts_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk      (clk),
    .wr       (wr),
    .rd_idx   (rd_idx),
    .rd_data_r(rd_data)
  );

  i2cmts_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_item(res),
    .full     (q_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // skid entry is only used behind a held result
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_tx_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.bus_action != ACT_SEND)) |-> (out_item.transmit_byte == 8'h00))
    else $error("transmit byte set without a send action");

  a_store_on_receive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.stored_valid) |->
      ((out_item.bus_action == ACT_RX_ACK) || (out_item.bus_action == ACT_RX_NACK) ||
       (out_item.bus_action == ACT_STOP)))
    else $error("stored byte reported without a receive decision");

endmodule

`default_nettype wire
